@@ rtl/sme_pkg.sv @@
// shared types and constants for the stack machine execute block
// no dependencies
package sme_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

  localparam logic [3:0] KIND_PUSH  = 4'd0;
  localparam logic [3:0] KIND_POP   = 4'd1;
  localparam logic [3:0] KIND_COPY  = 4'd2;
  localparam logic [3:0] KIND_ADD   = 4'd3;
  localparam logic [3:0] KIND_SUB   = 4'd4;
  localparam logic [3:0] KIND_MUL   = 4'd5;
  localparam logic [3:0] KIND_DIV   = 4'd6;
  localparam logic [3:0] KIND_REM   = 4'd7;
  localparam logic [3:0] KIND_PRINT = 4'd8;
  localparam logic [3:0] KIND_READ  = 4'd9;
  localparam logic [3:0] KIND_HALT  = 4'd10;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_DIV_ZERO  = 3'd3;
  localparam logic [2:0] ST_HALTED    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MUL, S_DIV, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_PUSH, ACT_COPY, ACT_POP, ACT_ADD, ACT_SUB,
    ACT_MUL_START, ACT_MUL_WB, ACT_DIV_START, ACT_DIV_WB
  } act_t;

  typedef struct packed {
    logic       load;
    act_t       act;
    logic       emit;
    logic [2:0] st;
    logic       pr;
  } cmd_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       empty;
    logic       lt2;
    logic       full;
    logic       top_zero;
    logic       div_done;
    logic       out_busy;
  } sts_t;

endpackage

@@ rtl/sme_in_if.sv @@
// input word channel: valid/ready handshake with instruction payload
// depends on sme_pkg
interface sme_in_if import sme_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [3:0]        kind;
  logic [DATA_W-1:0] argument;
  logic [DATA_W-1:0] read_value;

  modport source (output valid, kind, argument, read_value, input ready);
  modport sink (input valid, kind, argument, read_value, output ready);
endinterface

@@ rtl/sme_out_if.sv @@
// result word channel: valid/ready handshake with result payload
// depends on sme_pkg
interface sme_out_if import sme_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic              print_valid;
  logic [DATA_W-1:0] print_value;
  logic              top_valid;
  logic [DATA_W-1:0] top_value;
  logic [CNT_W-1:0]  depth;

  modport source (output valid, status, print_valid, print_value, top_valid,
                  top_value, depth, input ready);
  modport sink (input valid, status, print_valid, print_value, top_valid,
                top_value, depth, output ready);
endinterface

@@ rtl/stack_machine_execute_top.sv @@
// stack machine execute unit, top level
// depends on sme_pkg, sme_in_if, sme_out_if, sme_ctrl, sme_datapath
//
// in_ch carries one instruction word (kind, argument, read_value); out_ch
// returns one result word per instruction (status, printed value, top of
// stack, depth). both use valid/ready; a word moves when both are high.
// the unit works on one instruction at a time, stepping through states:
//   push, pop, copy, add, sub, print, read, halt, faults: exec, fin
//   mul: exec, mul, fin (product registered before write-back)
//   div, rem: exec, div, fin; the radix-2 divider gives one quotient bit
//   per cycle while in div
// the next word is taken once the unit is back in idle after issuing the
// result word. the result sits in an output register; the next instruction
// is accepted while it waits, but that one cannot finish until out_ch takes
// the previous word. reset clears the depth, the halt flag and both channels;
// stack entries below the top are undefined until pushed.
module stack_machine_execute_top import sme_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sme_in_if.sink    in_ch,
  sme_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic rdy;

  assign in_ch.ready = rdy;

  sme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  sme_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (in_ch.kind),
    .argument   (in_ch.argument),
    .read_value (in_ch.read_value),
    .out_ch     (out_ch)
  );

endmodule

@@ rtl/sme_datapath.sv @@
// stack datapath: top register, stack memory, multiplier, serial divider,
// result register; depends on sme_pkg and sme_out_if
module sme_datapath import sme_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [3:0]        kind,
  input  logic [DATA_W-1:0] argument,
  input  logic [DATA_W-1:0] read_value,
  sme_out_if.source         out_ch
);

  logic [DATA_W-1:0]    mem [STACK_DEPTH];
  logic [3:0]           kind_q;
  logic [DATA_W-1:0]    val_q;
  logic [DATA_W-1:0]    sec;
  logic [DATA_W-1:0]    tos;
  logic [CNT_W-1:0]     count;
  logic [DATA_W-1:0]    prod;
  logic [DATA_W-1:0]    pval;
  logic                 mem_we;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic [CNT_W-1:0]     cnt_m1;
  logic [CNT_W-1:0]     cnt_m2;

  logic [DATA_W-1:0]    div_rem;
  logic [DATA_W-1:0]    div_quo;
  logic [DATA_W-1:0]    div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 q_neg;
  logic                 r_neg;
  logic                 is_rem;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      trial;
  logic [DATA_W-1:0]    abs_s;
  logic [DATA_W-1:0]    abs_t;
  logic [DATA_W-1:0]    div_res;

  logic                 o_valid;
  logic [2:0]           o_status;
  logic                 o_pvalid;
  logic [DATA_W-1:0]    o_pvalue;
  logic                 o_tvalid;
  logic [DATA_W-1:0]    o_tvalue;
  logic [CNT_W-1:0]     o_depth;

  assign cnt_m1  = count - CNT_W'(1);
  assign cnt_m2  = count - CNT_W'(2);
  assign wr_addr = cnt_m1[ADDR_W-1:0];
  assign rd_addr = cnt_m2[ADDR_W-1:0];
  assign mem_we  = (cmd.act == ACT_COPY) || ((cmd.act == ACT_PUSH) && (count != '0));

  assign abs_s   = sec[DATA_W-1] ? -sec : sec;
  assign abs_t   = tos[DATA_W-1] ? -tos : tos;
  assign shifted = {div_rem, div_quo[DATA_W-1]};
  assign trial   = shifted - {1'b0, div_den};
  assign div_res = is_rem ? (r_neg ? -div_rem : div_rem) : (q_neg ? -div_quo : div_quo);

  always_comb begin
    sts.kind     = kind_q;
    sts.empty    = (count == '0);
    sts.lt2      = (count < CNT_W'(2));
    sts.full     = (count >= CNT_W'(STACK_DEPTH));
    sts.top_zero = (tos == '0);
    sts.div_done = (div_cnt == '0);
    sts.out_busy = o_valid && !out_ch.ready;
  end

  // stack memory, top of stack lives in tos
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= tos;
    end
    if (cmd.load) begin
      sec <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      val_q  <= (kind == KIND_READ) ? read_value : argument;
    end
    case (cmd.act)
      ACT_PUSH: tos <= val_q;
      ACT_POP: begin
        tos  <= sec;
        pval <= tos;
      end
      ACT_ADD:    tos <= sec + tos;
      ACT_SUB:    tos <= sec - tos;
      ACT_MUL_START: prod <= sec * tos;
      ACT_MUL_WB: tos <= prod;
      ACT_DIV_WB: tos <= div_res;
      default: ;
    endcase
    if (cmd.act == ACT_DIV_START) begin
      div_rem <= '0;
      div_quo <= abs_s;
      div_den <= abs_t;
      q_neg   <= sec[DATA_W-1] ^ tos[DATA_W-1];
      r_neg   <= sec[DATA_W-1];
      is_rem  <= (kind_q == KIND_REM);
    end else if (div_cnt != '0) begin
      if (!trial[DATA_W]) begin
        div_rem <= trial[DATA_W-1:0];
        div_quo <= {div_quo[DATA_W-2:0], 1'b1};
      end else begin
        div_rem <= shifted[DATA_W-1:0];
        div_quo <= {div_quo[DATA_W-2:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      o_status <= cmd.st;
      o_pvalid <= cmd.pr;
      o_pvalue <= cmd.pr ? pval : '0;
      o_tvalid <= (count != '0);
      o_tvalue <= (count != '0) ? tos : '0;
      o_depth  <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      div_cnt <= '0;
      o_valid <= 1'b0;
    end else begin
      case (cmd.act)
        ACT_PUSH, ACT_COPY: count <= count + CNT_W'(1);
        ACT_POP, ACT_ADD, ACT_SUB, ACT_MUL_WB, ACT_DIV_WB: count <= cnt_m1;
        default: ;
      endcase
      if (cmd.act == ACT_DIV_START) begin
        div_cnt <= DIV_CNT_W'(DATA_W);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      if (cmd.emit) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.status      = o_status;
  assign out_ch.print_valid = o_pvalid;
  assign out_ch.print_value = o_pvalue;
  assign out_ch.top_valid   = o_tvalid;
  assign out_ch.top_value   = o_tvalue;
  assign out_ch.depth       = o_depth;

endmodule

@@ rtl/sme_ctrl.sv @@
// instruction sequencer: decodes the word, checks stack limits, steps
// the datapath; depends on sme_pkg
module sme_ctrl import sme_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state, state_next;
  logic       halted, halted_next;
  logic [2:0] st, st_next;
  logic       pr, pr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      halted <= 1'b0;
      st     <= ST_OK;
      pr     <= 1'b0;
    end else begin
      state  <= state_next;
      halted <= halted_next;
      st     <= st_next;
      pr     <= pr_next;
    end
  end

  always_comb begin
    state_next  = state;
    halted_next = halted;
    st_next     = st;
    pr_next     = pr;
    in_ready    = 1'b0;
    cmd         = '{load: 1'b0, act: ACT_NONE, emit: 1'b0, st: st, pr: pr};
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        st_next    = ST_OK;
        pr_next    = 1'b0;
        state_next = S_FIN;
        if (halted) begin
          st_next = ST_HALTED;
        end else begin
          case (sts.kind)
            KIND_PUSH, KIND_READ: begin
              if (sts.full) st_next = ST_OVERFLOW;
              else cmd.act = ACT_PUSH;
            end
            KIND_POP, KIND_PRINT: begin
              if (sts.empty) st_next = ST_UNDERFLOW;
              else begin
                cmd.act = ACT_POP;
                pr_next = (sts.kind == KIND_PRINT);
              end
            end
            KIND_COPY: begin
              if (sts.empty) st_next = ST_UNDERFLOW;
              else if (sts.full) st_next = ST_OVERFLOW;
              else cmd.act = ACT_COPY;
            end
            KIND_ADD, KIND_SUB, KIND_MUL: begin
              if (sts.lt2) st_next = ST_UNDERFLOW;
              else if (sts.kind == KIND_ADD) cmd.act = ACT_ADD;
              else if (sts.kind == KIND_SUB) cmd.act = ACT_SUB;
              else begin
                cmd.act    = ACT_MUL_START;
                state_next = S_MUL;
              end
            end
            KIND_DIV, KIND_REM: begin
              if (sts.lt2) st_next = ST_UNDERFLOW;
              else if (sts.top_zero) st_next = ST_DIV_ZERO;
              else begin
                cmd.act    = ACT_DIV_START;
                state_next = S_DIV;
              end
            end
            KIND_HALT: halted_next = 1'b1;
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd.act    = ACT_MUL_WB;
        state_next = S_FIN;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.act    = ACT_DIV_WB;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ sim/tb_stack_if.sv @@
`timescale 1ns / 100ps
// testbench copy of the word channels is not needed; this file holds the shared
// instruction word and outcome types used by the testbench, depends on sme_pkg
package tb_stack_pkg;
  import sme_pkg::*;

  typedef struct packed {
    logic [3:0]        kind;
    logic [DATA_W-1:0] argument;
    logic [DATA_W-1:0] read_value;
  } instr_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              print_valid;
    logic [DATA_W-1:0] print_value;
    logic              top_valid;
    logic [DATA_W-1:0] top_value;
    logic [CNT_W-1:0]  depth;
  } outcome_t;
endpackage

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// testbench for stack_machine_execute_top: directed table, overflow fill,
// receiver hold, random words, halt tail; checked by an in-bench stack predictor
// depends on sme_pkg, sme_in_if, sme_out_if, tb_stack_pkg and the rtl
module tb_top;
  import sme_pkg::*;
  import tb_stack_pkg::*;

  localparam int LIMIT = 3000000;

  logic clk;
  logic rst;
  sme_in_if  in_ch ();
  sme_out_if out_ch ();

  stack_machine_execute_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  logic [DATA_W-1:0] stk [STACK_DEPTH];
  int                stk_cnt;
  bit                stk_halted;
  outcome_t          pending_q [$];
  int                errors;
  int                checked;
  int                prints;
  int                faults;
  int                cycles;
  bit                rx_idle_on;
  int                hold_cycles;

  typedef struct {
    instr_t   ins;
    bit       fixed;
    outcome_t res;
  } row_t;
  row_t rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] sdiv(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                              bit want_rem);
    logic [DATA_W-1:0] ua, ub, q, r;
    ua = a[DATA_W-1] ? -a : a;
    ub = b[DATA_W-1] ? -b : b;
    q = ua / ub;
    r = ua % ub;
    if (want_rem) return a[DATA_W-1] ? -r : r;
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
  endfunction

  function automatic outcome_t stack_exec(instr_t w);
    outcome_t o;
    logic [DATA_W-1:0] t, s, r;
    o = '0;
    if (stk_halted) begin
      o.status = ST_HALTED;
    end else begin
      case (w.kind)
        KIND_PUSH, KIND_READ: begin
          if (stk_cnt >= STACK_DEPTH) o.status = ST_OVERFLOW;
          else begin
            stk[stk_cnt] = (w.kind == KIND_PUSH) ? w.argument : w.read_value;
            stk_cnt++;
          end
        end
        KIND_POP, KIND_PRINT: begin
          if (stk_cnt < 1) o.status = ST_UNDERFLOW;
          else begin
            stk_cnt--;
            if (w.kind == KIND_PRINT) begin
              o.print_valid = 1'b1;
              o.print_value = stk[stk_cnt];
            end
          end
        end
        KIND_COPY: begin
          if (stk_cnt < 1) o.status = ST_UNDERFLOW;
          else if (stk_cnt >= STACK_DEPTH) o.status = ST_OVERFLOW;
          else begin
            stk[stk_cnt] = stk[stk_cnt-1];
            stk_cnt++;
          end
        end
        KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_REM: begin
          if (stk_cnt < 2) o.status = ST_UNDERFLOW;
          else begin
            t = stk[stk_cnt-1];
            s = stk[stk_cnt-2];
            if ((w.kind == KIND_DIV || w.kind == KIND_REM) && t == '0) begin
              o.status = ST_DIV_ZERO;
            end else begin
              case (w.kind)
                KIND_ADD: r = s + t;
                KIND_SUB: r = s - t;
                KIND_MUL: r = s * t;
                KIND_DIV: r = sdiv(s, t, 1'b0);
                default:  r = sdiv(s, t, 1'b1);
              endcase
              stk_cnt--;
              stk[stk_cnt-1] = r;
            end
          end
        end
        KIND_HALT: stk_halted = 1'b1;
        default: ;
      endcase
    end
    o.top_valid = stk_cnt > 0;
    o.top_value = stk_cnt > 0 ? stk[stk_cnt-1] : '0;
    o.depth     = CNT_W'(stk_cnt);
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, checked);
  endtask

  // result side
  initial begin
    outcome_t e;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (pending_q.size() == 0) report("unexpected word", 0, 0);
        else begin
          e = pending_q.pop_front();
          if (out_ch.status !== e.status) report("status", out_ch.status, e.status);
          if (out_ch.print_valid !== e.print_valid)
            report("print_valid", out_ch.print_valid, e.print_valid);
          if (out_ch.print_value !== e.print_value)
            report("print_value", out_ch.print_value, e.print_value);
          if (out_ch.top_valid !== e.top_valid)
            report("top_valid", out_ch.top_valid, e.top_valid);
          if (out_ch.top_value !== e.top_value)
            report("top_value", out_ch.top_value, e.top_value);
          if (out_ch.depth !== e.depth) report("depth", out_ch.depth, e.depth);
          if (e.print_valid) prints++;
          if (e.status != ST_OK) faults++;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        hold_cycles = $urandom_range(0, 15);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send(instr_t w, bit tx_idle);
    int gap;
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= w.kind;
    in_ch.argument   <= w.argument;
    in_ch.read_value <= w.read_value;
    do @(posedge clk); while (!in_ch.ready);
    pending_q = {pending_q, stack_exec(w)};
  endtask

  function automatic instr_t mk(logic [3:0] k, logic [31:0] a, logic [31:0] rv);
    instr_t w;
    w.kind = k;
    w.argument = a;
    w.read_value = rv;
    return w;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] rand_kind();
    int p;
    p = $urandom_range(0, 99);
    if (stk_cnt < 3 && p < 40) return KIND_PUSH;
    if (stk_cnt > 56 && p < 40) return KIND_POP;
    if (p < 3) return 4'($urandom_range(11, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  task automatic add_row(instr_t w, bit fixed, outcome_t r);
    row_t x;
    x.ins = w;
    x.fixed = fixed;
    x.res = r;
    rows = {rows, x};
  endtask

  function automatic outcome_t fix(logic [2:0] st, logic [31:0] tv, int d);
    outcome_t o;
    o = '0;
    o.status = st;
    o.top_valid = d > 0;
    o.top_value = tv;
    o.depth = CNT_W'(d);
    return o;
  endfunction

  initial begin
    instr_t w;
    outcome_t e;
    int n;
    errors = 0;
    checked = 0;
    prints = 0;
    faults = 0;
    hold_cycles = 0;
    rx_idle_on = 1'b1;
    stk_cnt = 0;
    stk_halted = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.argument = '0;
    in_ch.read_value = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(mk(KIND_POP, 0, 0), 1, fix(ST_UNDERFLOW, 0, 0));
    add_row(mk(KIND_COPY, 0, 0), 1, fix(ST_UNDERFLOW, 0, 0));
    add_row(mk(KIND_PRINT, 0, 0), 1, fix(ST_UNDERFLOW, 0, 0));
    add_row(mk(KIND_PUSH, 32'h8000_0000, 0), 1, fix(ST_OK, 32'h8000_0000, 1));
    add_row(mk(KIND_ADD, 0, 0), 1, fix(ST_UNDERFLOW, 32'h8000_0000, 1));
    add_row(mk(KIND_READ, 0, 32'hffff_ffff), 1, fix(ST_OK, 32'hffff_ffff, 2));
    add_row(mk(KIND_DIV, 0, 0), 0, '0);
    add_row(mk(KIND_PUSH, 32'h7fff_ffff, 0), 0, '0);
    add_row(mk(KIND_PUSH, 0, 0), 0, '0);
    add_row(mk(KIND_DIV, 0, 0), 0, '0);
    add_row(mk(KIND_REM, 0, 0), 0, '0);
    add_row(mk(KIND_POP, 0, 0), 0, '0);
    add_row(mk(KIND_PUSH, 32'hffff_ffff, 0), 0, '0);
    add_row(mk(KIND_REM, 0, 0), 0, '0);
    add_row(mk(KIND_PUSH, 32'hffff_fff9, 0), 0, '0);
    add_row(mk(KIND_MUL, 0, 0), 0, '0);
    add_row(mk(KIND_COPY, 0, 0), 0, '0);
    add_row(mk(KIND_SUB, 0, 0), 0, '0);
    add_row(mk(KIND_READ, 0, 32'h7fff_ffff), 0, '0);
    add_row(mk(KIND_ADD, 0, 0), 0, '0);
    add_row(mk(4'd15, 32'hffff_ffff, 32'hffff_ffff), 0, '0);
    add_row(mk(KIND_PRINT, 0, 0), 0, '0);

    foreach (rows[i]) begin
      if (rows[i].fixed) begin
        e = stack_exec(rows[i].ins);
        if (e !== rows[i].res) report("directed row", i, 0);
        // rewind: table rows feed the predictor again in send
        stk_cnt = rows[i].res.depth;
        if (rows[i].ins.kind == KIND_PUSH || rows[i].ins.kind == KIND_READ)
          if (rows[i].res.status == ST_OK) stk_cnt--;
        if (rows[i].ins.kind == KIND_HALT) stk_halted = 1'b0;
      end
      send(rows[i].ins, 1'b1);
    end

    // fill to overflow
    while (stk_cnt < STACK_DEPTH) send(mk(KIND_PUSH, $urandom, 0), 1'b1);
    send(mk(KIND_PUSH, 1, 0), 1'b1);
    send(mk(KIND_READ, 0, 2), 1'b1);
    send(mk(KIND_COPY, 0, 0), 1'b1);
    in_ch.valid <= 1'b0;

    // long receiver hold while sender keeps offering
    wait (pending_q.size() == 0);
    hold_cycles = 300;
    for (n = 0; n < 20; n++) send(mk(KIND_ADD, 0, 0), 1'b0);
    in_ch.valid <= 1'b0;
    // sender pauses until all results have come
    wait (pending_q.size() == 0);

    for (n = 0; n < 820; n++) begin
      w.kind = rand_kind();
      w.argument = rand_val();
      w.read_value = rand_val();
      if (n > 720) rx_idle_on = 1'b0;
      send(w, n <= 720);
    end

    send(mk(KIND_HALT, 0, 0), 1'b0);
    for (n = 0; n < 20; n++) begin
      w.kind = 4'($urandom_range(0, 15));
      w.argument = $urandom;
      w.read_value = $urandom;
      send(w, 1'b0);
    end
    in_ch.valid <= 1'b0;

    n = 0;
    while (pending_q.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (50) @(posedge clk);
    if (pending_q.size() != 0) report("results left over", pending_q.size(), 0);
    $display("covered %0d results, %0d prints, %0d faulting words incl. halt tail",
             checked, prints, faults);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
